### src/baro_temp_pressure_compensation_core_macros.svh
// Assertion macros for the barometric compensation core.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_CORE_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BTPC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("btpc assertion failed");
`define BTPC_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("btpc reset assertion failed");
`else
`define BTPC_ASSERT(lbl, clk, rst_n, prop)
`define BTPC_ASSERT_RST(lbl, clk, prop)
`endif
`endif

### src/btpc_pkg.sv
// Shared types, register indexes and helper arithmetic for the compensation core.
// No dependencies.
package btpc_pkg;

  typedef enum logic [1:0] {
    CFG_TEMP_CAL    = 2'd0,
    CFG_PRESS_CAL_A = 2'd1,
    CFG_PRESS_CAL_B = 2'd2,
    CFG_PRESS_CAL_C = 2'd3
  } cfg_idx_t;

  localparam int DIV_BITS = 64;

  // Result fields that ride alongside the pressure datapath.
  typedef struct packed {
    logic [23:0] tc;
    logic [31:0] fine;
    logic        inval;
  } side_t;

  // Low 64 bits of a 64-bit word times a 17-bit signed value, built from two
  // partial products: a 33 by 17 bit signed one and one truncated to 32 bits.
  function automatic logic [63:0] mul64x17_lo(input logic [63:0] a,
                                              input logic signed [16:0] b);
    logic signed [49:0] lo;
    logic [31:0]        hi;
    lo = $signed({1'b0, a[31:0]}) * b;
    hi = 32'(a[63:32] * {{15{b[16]}}, b});
    return {{14{lo[49]}}, lo} + {hi, 32'h0};
  endfunction

endpackage

### src/btpc_div.sv
// Pipelined signed 64 by 31 bit divider, one quotient bit per stage.
// Depends on btpc_pkg for the sideband type and the stage count.
module btpc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [63:0]           dividend,
  input  logic [30:0]           divisor,
  input  btpc_pkg::side_t       in_side,
  output logic                  out_valid,
  output logic [63:0]           quotient,
  output btpc_pkg::side_t       out_side
);

  localparam int N = btpc_pkg::DIV_BITS;

  logic                  vld_r  [0:N+1];
  logic [63:0]           sh_r   [0:N];
  logic [30:0]           rem_r  [0:N];
  logic [30:0]           dmag_r [0:N];
  logic                  neg_r  [0:N];
  btpc_pkg::side_t       side_r [0:N+1];
  logic [63:0]           q_r;

  // Entry stage: take magnitudes; the sign of the quotient travels along.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sh_r[0]   <= dividend[63] ? 64'(0 - dividend) : dividend;
      dmag_r[0] <= divisor[30] ? 31'(0 - divisor) : divisor;
      neg_r[0]  <= dividend[63] ^ divisor[30];
      rem_r[0]  <= '0;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [31:0] trial;
    logic        ge;
    logic [31:0] diff;
    assign trial = {rem_r[k-1], sh_r[k-1][63]};
    assign diff  = trial - {1'b0, dmag_r[k-1]};
    assign ge    = trial >= {1'b0, dmag_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= ge ? diff[30:0] : trial[30:0];
        sh_r[k]   <= {sh_r[k-1][62:0], ge};
        dmag_r[k] <= dmag_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[N+1] <= 1'b0;
    end else if (adv) begin
      vld_r[N+1] <= vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r         <= neg_r[N] ? 64'(0 - sh_r[N]) : sh_r[N];
      side_r[N+1] <= side_r[N];
    end
  end

  assign out_valid = vld_r[N+1];
  assign quotient  = q_r;
  assign out_side  = side_r[N+1];

endmodule

### src/baro_temp_pressure_compensation_core.sv
// Top level of the barometric temperature and pressure compensation core.
// Depends on btpc_pkg, btpc_div and the assertion macro header.
//
// Usage: calibration words are written through cfg_we/cfg_addr/cfg_wdata
// while no beat is in flight. Each input beat carries one raw pressure and
// one raw temperature reading; each output beat carries the compensated
// temperature, fine temperature and pressure, with out_tuser flagging a
// zero pressure divisor (pressure then reads as zero).
// Throughput: one beat per cycle unless a stall holds the pipeline. An
// accepted input beat reaches out_tvalid through the multiplier stages
// ahead of the divider, its 64 single-bit stages and those behind it.
// The whole pipeline advances together: when out_tvalid is high and
// out_tready low, every stage holds and in_tready drops, so nothing is lost
// or repeated; empty stages hold as well while a result waits.
// Reset clears all valid bits and the calibration words; the block is ready
// for beats in the first cycle after reset.
`include "baro_temp_pressure_compensation_core_macros.svh"
module baro_temp_pressure_compensation_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [47:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // raw_pressure[19:0], raw_temperature[39:20]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // temperature_centi[23:0], fine_temperature[55:24],
                                  // pressure_q24_8[87:56]
  output logic        out_tuser   // pressure_invalid
);

  logic [47:0] tcal_r, pcal_a_r, pcal_b_r, pcal_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcal_r   <= '0;
      pcal_a_r <= '0;
      pcal_b_r <= '0;
      pcal_c_r <= '0;
    end else if (cfg_we) begin
      case (btpc_pkg::cfg_idx_t'(cfg_addr))
        btpc_pkg::CFG_TEMP_CAL:    tcal_r   <= cfg_wdata;
        btpc_pkg::CFG_PRESS_CAL_A: pcal_a_r <= cfg_wdata;
        btpc_pkg::CFG_PRESS_CAL_B: pcal_b_r <= cfg_wdata;
        btpc_pkg::CFG_PRESS_CAL_C: pcal_c_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = tcal_r[15:0];
  assign t2 = $signed(tcal_r[31:16]);
  assign t3 = $signed(tcal_r[47:32]);
  assign p1 = pcal_a_r[15:0];
  assign p2 = $signed(pcal_a_r[31:16]);
  assign p3 = $signed(pcal_a_r[47:32]);
  assign p4 = $signed(pcal_b_r[15:0]);
  assign p5 = $signed(pcal_b_r[31:16]);
  assign p6 = $signed(pcal_b_r[47:32]);
  assign p7 = $signed(pcal_c_r[15:0]);
  assign p8 = $signed(pcal_c_r[31:16]);
  assign p9 = $signed(pcal_c_r[47:32]);

  logic en;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  // Valid bits of the stages ahead of the divider.
  logic [10:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[9:0], in_tvalid};
    end
  end

  // Raw pressure is carried until the numerator is formed.
  logic [19:0] adcp_r [0:8];
  logic [19:0] adct_r;

  always_ff @(posedge clk) begin
    if (en) begin
      adcp_r[0] <= in_tdata[19:0];
      adct_r    <= in_tdata[39:20];
      for (int i = 1; i < 9; i++) begin
        adcp_r[i] <= adcp_r[i-1];
      end
    end
  end

  // Temperature: differences against T1 and the first products.
  logic signed [17:0] a_nxt;
  logic signed [16:0] d_nxt;
  logic signed [33:0] at2_full, dd_full;
  logic [31:0]        at2_r, dd_r;
  assign a_nxt    = $signed({1'b0, adct_r[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign d_nxt    = $signed({1'b0, adct_r[19:4]}) - $signed({1'b0, t1});
  assign at2_full = a_nxt * t2;
  assign dd_full  = d_nxt * d_nxt;

  // Only the low 20 bits of the shifted square feed the T3 product, as signed.
  logic signed [31:0] dd_sh;
  logic signed [35:0] dt3_full;
  logic [31:0]        v1_r, dt3_r;
  assign dd_sh    = $signed(dd_r) >>> 12;
  assign dt3_full = $signed(dd_sh[19:0]) * t3;

  logic signed [31:0] fine_nxt;
  logic [31:0]        fine_r;
  assign fine_nxt = $signed(v1_r) + ($signed(dt3_r) >>> 14);

  logic [31:0]        fine5;
  logic signed [32:0] x1_nxt, x1_r;
  assign fine5  = (fine_r << 2) + fine_r + 32'd128;
  assign x1_nxt = $signed({fine_r[31], fine_r}) - 33'sd128000;

  always_ff @(posedge clk) begin
    if (en) begin
      at2_r  <= at2_full[31:0];
      dd_r   <= dd_full[31:0];
      v1_r   <= 32'($signed(at2_r) >>> 11);
      dt3_r  <= dt3_full[31:0];
      fine_r <= 32'(fine_nxt);
      x1_r   <= x1_nxt;
    end
  end

  // Sideband results travel from stage 4 onwards.
  btpc_pkg::side_t side_r [4:10];
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[4] <= '{tc: fine5[31:8], fine: fine_r, inval: 1'b0};
      for (int i = 5; i <= 10; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Pressure: the var1/var2 chain, one multiplier level per stage.
  logic signed [65:0] sq_full;
  logic signed [48:0] x1p5_nxt, x1p2_nxt;
  logic [63:0]        sq_r, sqp6_r, sqp3_r, x2a_r, x2_r, var1_r, v_r, n0_r, pv_r, num_r;
  logic signed [48:0] x1p5_r, x1p5b_r, x1p2_r;
  logic signed [32:0] x1b_r;
  logic [30:0]        den_r;
  assign sq_full  = x1_r * x1_r;
  assign x1p5_nxt = x1_r * p5;
  assign x1p2_nxt = x1b_r * p2;

  logic [20:0] pr0;
  assign pr0 = 21'h100000 - {1'b0, adcp_r[8]};

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r    <= sq_full[63:0];
      x1p5_r  <= x1p5_nxt;
      x1b_r   <= x1_r;
      sqp6_r  <= btpc_pkg::mul64x17_lo(sq_r, {p6[15], p6});
      x1p2_r  <= x1p2_nxt;
      x1p5b_r <= x1p5_r;
      sqp3_r  <= btpc_pkg::mul64x17_lo(sq_r, {p3[15], p3});
      x2a_r   <= sqp6_r + {x1p5b_r[46:0], 17'h0};
      x2_r    <= x2a_r + {{13{p4[15]}}, p4, 35'h0};
      var1_r  <= 64'($signed(sqp3_r) >>> 8) + {{3{x1p2_r[48]}}, x1p2_r, 12'h0};
      v_r     <= var1_r + 64'h0000_8000_0000_0000;
      n0_r    <= {12'h0, pr0, 31'h0} - x2_r;
      pv_r    <= btpc_pkg::mul64x17_lo(v_r, {1'b0, p1});
      num_r   <= btpc_pkg::mul64x17_lo(n0_r, 17'sd3125);
      den_r   <= pv_r[63:33];
    end
  end

  // The divisor is (var1 + 2^47) times P1 shifted down by 33, so it fits in 31 signed bits.
  logic [30:0]     divisor;
  btpc_pkg::side_t div_side;
  assign divisor  = den_r;
  assign div_side = '{tc: side_r[10].tc, fine: side_r[10].fine, inval: divisor == 31'h0};

  logic            dvld;
  logic [63:0]     q;
  btpc_pkg::side_t dside;

  btpc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (en),
    .in_valid  (vld_r[10]),
    .dividend  (num_r),
    .divisor   (divisor),
    .in_side   (div_side),
    .out_valid (dvld),
    .quotient  (q),
    .out_side  (dside)
  );

  // Back end: the P9 term needs the square of (p >> 13) modulo 2^64.
  logic [63:0]     hi;
  assign hi = 64'($signed(q) >>> 13);

  logic [4:0]      pvld_r;
  btpc_pkg::side_t bside_r [0:4];
  logic [63:0]     q12_r, q13_r, q14_r, q15_r;
  logic [31:0]     lo12_r, h12_r, lh_r;
  logic [63:0]     ll_r, ll13_r, p8q12_r, p8q13_r, p8q14_r, p8q15_r, hsq_r, sqp9_r, sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= '0;
    end else if (en) begin
      pvld_r <= {pvld_r[3:0], dvld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q12_r      <= q;
      lo12_r     <= hi[31:0];
      h12_r      <= hi[63:32];
      ll_r       <= {32'h0, hi[31:0]} * {32'h0, hi[31:0]};
      p8q12_r    <= btpc_pkg::mul64x17_lo(q, {p8[15], p8});
      bside_r[0] <= dside;

      q13_r      <= q12_r;
      lh_r       <= 32'(lo12_r * h12_r);
      ll13_r     <= ll_r;
      p8q13_r    <= p8q12_r;
      bside_r[1] <= bside_r[0];

      q14_r      <= q13_r;
      hsq_r      <= ll13_r + {lh_r[30:0], 33'h0};
      p8q14_r    <= p8q13_r;
      bside_r[2] <= bside_r[1];

      q15_r      <= q14_r;
      sqp9_r     <= btpc_pkg::mul64x17_lo(hsq_r, {p9[15], p9});
      p8q15_r    <= p8q14_r;
      bside_r[3] <= bside_r[2];

      sum_r      <= q15_r + 64'($signed(sqp9_r) >>> 25) + 64'($signed(p8q15_r) >>> 19);
      bside_r[4] <= bside_r[3];
    end
  end

  logic [63:0] pres_nxt;
  assign pres_nxt = 64'($signed(sum_r) >>> 8) + {{44{p7[15]}}, p7, 4'h0};

  logic        out_valid_r;
  logic [87:0] out_data_r;
  logic        out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pvld_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {bside_r[4].inval ? 32'h0 : pres_nxt[31:0],
                     bside_r[4].fine, bside_r[4].tc};
      out_user_r <= bside_r[4].inval;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `BTPC_ASSERT(a_accept_enters, clk, rst_n, (in_tvalid && in_tready) |=> vld_r[0])
  `BTPC_ASSERT(a_invalid_zero, clk, rst_n, (out_tvalid && out_tuser) |-> (out_tdata[87:56] == 32'h0))
  `BTPC_ASSERT(a_stall_holds_div, clk, rst_n, !en |=> $stable(dvld))
  `BTPC_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_tvalid)

endmodule
